// ----- sv/tptq_pkg.sv -----
// Package for the two-lane priority transmit queue: sizes, codes, payload structs
// and the small helper functions for addressing and the CAN-FD length code.
// No dependencies.
package tptq_pkg;

	localparam int HIGH_LANE_DEPTH = 32;
	localparam int LOW_LANE_DEPTH  = 320;
	localparam int WORDS_PER_FRAME = 8;

	localparam int ID_W   = 29;
	localparam int LEN_W  = 7;
	localparam int WORD_W = 64;
	localparam int DLC_W  = 4;
	localparam int POS_W  = 5;
	localparam int HDR_W  = ID_W + LEN_W;

	localparam int HI_W   = $clog2(HIGH_LANE_DEPTH);
	localparam int LO_W   = $clog2(LOW_LANE_DEPTH);
	localparam int SLOT_W = (LO_W > HI_W) ? LO_W : HI_W;
	localparam int CNT_W  = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;

	localparam int HDR_DEPTH  = HIGH_LANE_DEPTH + LOW_LANE_DEPTH;
	localparam int WORD_DEPTH = HDR_DEPTH * WORDS_PER_FRAME;
	localparam int HADDR_W    = $clog2(HDR_DEPTH);
	localparam int WADDR_W    = $clog2(WORD_DEPTH);

	localparam logic [POS_W-1:0] PRIO_POS_RESET = POS_W'(28);

	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_POP     = 1'b1;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_WORD   = 2'd1;
	localparam logic [1:0] KIND_EMPTY  = 2'd2;

	localparam logic LANE_HIGH = 1'b0;
	localparam logic LANE_LOW  = 1'b1;

	typedef struct packed {
		logic              command;
		logic [ID_W-1:0]   frame_id;
		logic [LEN_W-1:0]  frame_length;
		logic [WORD_W-1:0] payload_word;
		logic              word_last;
	} tptq_in_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic              enqueue_status;
		logic              lane_used;
		logic [ID_W-1:0]   out_frame_id;
		logic [DLC_W-1:0]  out_dlc;
		logic [LEN_W-1:0]  out_length;
		logic [WORD_W-1:0] out_payload_word;
		logic              out_word_last;
		logic              error_flag;
	} tptq_out_t;

	function automatic logic [DLC_W-1:0] fd_dlc(input logic [LEN_W-1:0] len);
		logic [DLC_W-1:0] dlc;
		if (len <= LEN_W'(8))       dlc = DLC_W'(len);
		else if (len <= LEN_W'(12)) dlc = DLC_W'(9);
		else if (len <= LEN_W'(16)) dlc = DLC_W'(10);
		else if (len <= LEN_W'(20)) dlc = DLC_W'(11);
		else if (len <= LEN_W'(24)) dlc = DLC_W'(12);
		else if (len <= LEN_W'(32)) dlc = DLC_W'(13);
		else if (len <= LEN_W'(48)) dlc = DLC_W'(14);
		else                        dlc = DLC_W'(15);
		return dlc;
	endfunction

	function automatic logic [HADDR_W-1:0] hdr_addr(input logic lane,
			input logic [SLOT_W-1:0] slot);
		logic [HADDR_W-1:0] a;
		a = HADDR_W'(slot);
		if (lane == LANE_LOW)
			a = a + HADDR_W'(HIGH_LANE_DEPTH);
		return a;
	endfunction

	function automatic logic [WADDR_W-1:0] word_addr(input logic lane,
			input logic [SLOT_W-1:0] slot, input logic [CNT_W-1:0] k);
		logic [WADDR_W-1:0] base;
		base = WADDR_W'(hdr_addr(lane, slot));
		return base * WADDR_W'(WORDS_PER_FRAME) + WADDR_W'(k);
	endfunction

endpackage

// ----- sv/tptq_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module tptq_ram #(
	parameter int Width = 64,
	parameter int Depth = 256
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(Depth)-1:0]         wr_addr,
	input  logic [Width-1:0]                 wr_data,
	input  logic                             rd_en,
	input  logic [$clog2(Depth)-1:0]         rd_addr,
	output logic [Width-1:0]                 rd_data
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- sv/two_lane_priority_tx_queue_top.sv -----
// Top level of the two-lane strict-priority transmit queue.
// Depends on tptq_pkg and tptq_ram (one header memory, one payload word memory).
//
// Usage: the in channel carries one transaction per enqueued payload word or per
// pop request. Enqueue words are taken one per cycle while the block is idle
// and the output register is free; intermediate words give no result and
// the final word of a frame gives one status result. A pop reads the header
// memory in ST_HDR, then streams the frame's payload words from the word
// memory at one word per cycle while the receiver is ready; the first word
// is registered into the output register from ST_EMIT. A status result or
// the single result for an empty queue is registered at the edge of
// acceptance and is offered from the next cycle. The in channel
// is held off for the duration of a pop. Results sit in one output register; the
// block accepts a new transaction while that register is being taken. A stall on
// the out channel holds the register and, through it, the in channel and the
// word stream. The cfg channel is always ready and writes the priority bit
// position. Reset clears the ring indices, the frame loading state and the
// sticky error, and sets the priority bit position to 28; memory contents are
// not cleared and no clearing pass is needed.
module two_lane_priority_tx_queue_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  tptq_pkg::tptq_in_t           in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output tptq_pkg::tptq_out_t          out_item,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tptq_pkg::POS_W-1:0]   cfg_data
);
	import tptq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_HDR  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t             state_q, state_d;
	logic [POS_W-1:0]   prio_pos_q;
	logic [HI_W-1:0]    hi_wr_q, hi_wr_d, hi_rd_q, hi_rd_d;
	logic [LO_W-1:0]    lo_wr_q, lo_wr_d, lo_rd_q, lo_rd_d;
	logic [CNT_W-1:0]   load_cnt_q, load_cnt_d;
	logic               load_drop_q, load_drop_d;
	logic               load_lane_q, load_lane_d;
	logic               sticky_q, sticky_d;
	logic               pop_lane_q, pop_lane_d;
	logic [SLOT_W-1:0]  pop_slot_q, pop_slot_d;
	logic [CNT_W-1:0]   word_k_q, word_k_d;
	logic [CNT_W-1:0]   last_k_q, last_k_d;
	logic [ID_W-1:0]    pop_id_q, pop_id_d;
	logic [LEN_W-1:0]   pop_len_q, pop_len_d;
	logic [DLC_W-1:0]   pop_dlc_q, pop_dlc_d;
	logic               out_valid_q, out_valid_d;
	tptq_out_t          out_q, out_d;

	logic               out_free, in_fire;
	logic               first_word, prio_bit, lane_now, drop_now, end_now;
	logic [HI_W-1:0]    hi_wr_next, hi_rd_next;
	logic [LO_W-1:0]    lo_wr_next, lo_rd_next;
	logic               hi_full, lo_full, hi_nonempty, lo_nonempty;
	logic [SLOT_W-1:0]  wr_slot;
	logic [LEN_W:0]     word_span;
	logic [CNT_W-1:0]   rd_k;

	logic               hdr_wr_en, hdr_rd_en, word_wr_en, word_rd_en;
	logic [HADDR_W-1:0] hdr_wr_addr, hdr_rd_addr;
	logic [WADDR_W-1:0] word_wr_addr, word_rd_addr;
	logic [HDR_W-1:0]   hdr_wr_data, hdr_rd_data;
	logic [WORD_W-1:0]  word_rd_data;

	tptq_ram #(.Width(HDR_W), .Depth(HDR_DEPTH)) u_hdr_ram (
		.clk     (clk),
		.wr_en   (hdr_wr_en),
		.wr_addr (hdr_wr_addr),
		.wr_data (hdr_wr_data),
		.rd_en   (hdr_rd_en),
		.rd_addr (hdr_rd_addr),
		.rd_data (hdr_rd_data)
	);

	tptq_ram #(.Width(WORD_W), .Depth(WORD_DEPTH)) u_word_ram (
		.clk     (clk),
		.wr_en   (word_wr_en),
		.wr_addr (word_wr_addr),
		.wr_data (in_item.payload_word),
		.rd_en   (word_rd_en),
		.rd_addr (word_rd_addr),
		.rd_data (word_rd_data)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign hi_wr_next  = (hi_wr_q == HI_W'(HIGH_LANE_DEPTH - 1)) ? '0 : hi_wr_q + HI_W'(1);
	assign hi_rd_next  = (hi_rd_q == HI_W'(HIGH_LANE_DEPTH - 1)) ? '0 : hi_rd_q + HI_W'(1);
	assign lo_wr_next  = (lo_wr_q == LO_W'(LOW_LANE_DEPTH - 1)) ? '0 : lo_wr_q + LO_W'(1);
	assign lo_rd_next  = (lo_rd_q == LO_W'(LOW_LANE_DEPTH - 1)) ? '0 : lo_rd_q + LO_W'(1);
	assign hi_full     = (hi_wr_next == hi_rd_q);
	assign lo_full     = (lo_wr_next == lo_rd_q);
	assign hi_nonempty = (hi_rd_q != hi_wr_q);
	assign lo_nonempty = (lo_rd_q != lo_wr_q);

	assign first_word = (load_cnt_q == '0);
	assign prio_bit   = (prio_pos_q < POS_W'(ID_W)) ? in_item.frame_id[prio_pos_q] : 1'b0;
	assign lane_now   = first_word ? prio_bit : load_lane_q;
	assign drop_now   = first_word ? ((lane_now == LANE_LOW) ? lo_full : hi_full)
		: load_drop_q;
	assign end_now    = in_item.word_last || (load_cnt_q == CNT_W'(WORDS_PER_FRAME - 1));
	assign wr_slot    = (lane_now == LANE_LOW) ? SLOT_W'(lo_wr_q) : SLOT_W'(hi_wr_q);
	assign word_span  = ({1'b0, hdr_rd_data[HDR_W-1:ID_W]} + (LEN_W+1)'(7)) >> 3;
	assign rd_k       = (state_q == ST_HDR) ? '0 : word_k_q + CNT_W'(1);

	assign word_wr_addr = word_addr(lane_now, wr_slot, load_cnt_q);
	assign hdr_wr_addr  = hdr_addr(lane_now, wr_slot);
	assign hdr_wr_data  = {in_item.frame_length, in_item.frame_id};
	assign hdr_rd_addr  = hi_nonempty ? hdr_addr(LANE_HIGH, SLOT_W'(hi_rd_q))
		: hdr_addr(LANE_LOW, SLOT_W'(lo_rd_q));
	assign word_rd_addr = word_addr(pop_lane_q, pop_slot_q, rd_k);

	always_comb begin
		state_d     = state_q;
		hi_wr_d     = hi_wr_q;
		hi_rd_d     = hi_rd_q;
		lo_wr_d     = lo_wr_q;
		lo_rd_d     = lo_rd_q;
		load_cnt_d  = load_cnt_q;
		load_drop_d = load_drop_q;
		load_lane_d = load_lane_q;
		sticky_d    = sticky_q;
		pop_lane_d  = pop_lane_q;
		pop_slot_d  = pop_slot_q;
		word_k_d    = word_k_q;
		last_k_d    = last_k_q;
		pop_id_d    = pop_id_q;
		pop_len_d   = pop_len_q;
		pop_dlc_d   = pop_dlc_q;
		out_valid_d = out_valid_q && !out_ready;
		out_d       = out_q;
		hdr_wr_en   = 1'b0;
		hdr_rd_en   = 1'b0;
		word_wr_en  = 1'b0;
		word_rd_en  = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_item.command == CMD_ENQUEUE) begin
					word_wr_en  = !drop_now;
					load_lane_d = lane_now;
					if (!end_now) begin
						load_cnt_d  = load_cnt_q + CNT_W'(1);
						load_drop_d = drop_now;
					end else begin
						load_cnt_d  = '0;
						load_drop_d = 1'b0;
						if (drop_now) begin
							sticky_d = 1'b1;
						end else begin
							hdr_wr_en = 1'b1;
							if (lane_now == LANE_LOW)
								lo_wr_d = lo_wr_next;
							else
								hi_wr_d = hi_wr_next;
						end
						out_valid_d          = 1'b1;
						out_d                = '0;
						out_d.result_kind    = KIND_STATUS;
						out_d.enqueue_status = drop_now;
						out_d.lane_used      = lane_now;
						out_d.out_word_last  = 1'b1;
						out_d.error_flag     = drop_now | sticky_q;
					end
				end else if (in_fire) begin
					if (hi_nonempty || lo_nonempty) begin
						hdr_rd_en = 1'b1;
						sticky_d  = 1'b0;
						state_d   = ST_HDR;
						if (hi_nonempty) begin
							pop_lane_d = LANE_HIGH;
							pop_slot_d = SLOT_W'(hi_rd_q);
							hi_rd_d    = hi_rd_next;
						end else begin
							pop_lane_d = LANE_LOW;
							pop_slot_d = SLOT_W'(lo_rd_q);
							lo_rd_d    = lo_rd_next;
						end
					end else begin
						out_valid_d         = 1'b1;
						out_d               = '0;
						out_d.result_kind   = KIND_EMPTY;
						out_d.out_word_last = 1'b1;
						out_d.error_flag    = sticky_q;
					end
				end
			end
			ST_HDR: begin
				pop_id_d   = hdr_rd_data[ID_W-1:0];
				pop_len_d  = hdr_rd_data[HDR_W-1:ID_W];
				pop_dlc_d  = fd_dlc(hdr_rd_data[HDR_W-1:ID_W]);
				word_k_d   = '0;
				word_rd_en = 1'b1;
				state_d    = ST_EMIT;
				if (word_span == '0)
					last_k_d = '0;
				else if (word_span > (LEN_W+1)'(WORDS_PER_FRAME))
					last_k_d = CNT_W'(WORDS_PER_FRAME - 1);
				else
					last_k_d = CNT_W'(word_span - (LEN_W+1)'(1));
			end
			ST_EMIT: begin
				if (out_free) begin
					out_valid_d            = 1'b1;
					out_d.result_kind      = KIND_WORD;
					out_d.enqueue_status   = 1'b0;
					out_d.lane_used        = pop_lane_q;
					out_d.out_frame_id     = pop_id_q;
					out_d.out_dlc          = pop_dlc_q;
					out_d.out_length       = pop_len_q;
					out_d.out_payload_word = word_rd_data;
					out_d.out_word_last    = (word_k_q == last_k_q);
					out_d.error_flag       = 1'b0;
					if (word_k_q == last_k_q) begin
						state_d = ST_IDLE;
					end else begin
						word_rd_en = 1'b1;
						word_k_d   = word_k_q + CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prio_pos_q  <= PRIO_POS_RESET;
			hi_wr_q     <= '0;
			hi_rd_q     <= '0;
			lo_wr_q     <= '0;
			lo_rd_q     <= '0;
			load_cnt_q  <= '0;
			load_drop_q <= 1'b0;
			load_lane_q <= 1'b0;
			sticky_q    <= 1'b0;
			word_k_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			hi_wr_q     <= hi_wr_d;
			hi_rd_q     <= hi_rd_d;
			lo_wr_q     <= lo_wr_d;
			lo_rd_q     <= lo_rd_d;
			load_cnt_q  <= load_cnt_d;
			load_drop_q <= load_drop_d;
			load_lane_q <= load_lane_d;
			sticky_q    <= sticky_d;
			word_k_q    <= word_k_d;
			out_valid_q <= out_valid_d;
			if (cfg_valid && cfg_ready)
				prio_pos_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		pop_lane_q <= pop_lane_d;
		pop_slot_q <= pop_slot_d;
		last_k_q   <= last_k_d;
		pop_id_q   <= pop_id_d;
		pop_len_q  <= pop_len_d;
		pop_dlc_q  <= pop_dlc_d;
		out_q      <= out_d;
	end

endmodule
